FILE: hdl/acf_pkg.sv
// Shared types and codes for the box cut fracture block.
// No dependencies; acf_front, acf_back, the core and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package acf_pkg;

  // Width of the configuration register index.
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CUT_MIN_X = 3'd0,
    CFG_CUT_MIN_Y = 3'd1,
    CFG_CUT_MIN_Z = 3'd2,
    CFG_CUT_MAX_X = 3'd3,
    CFG_CUT_MAX_Y = 3'd4,
    CFG_CUT_MAX_Z = 3'd5
  } cfg_reg_e;

  // Position of a span on one axis relative to the cut box.
  typedef enum logic [1:0] {
    SPAN_BELOW  = 2'd0,
    SPAN_INSIDE = 2'd1,
    SPAN_ABOVE  = 2'd2
  } span_e;

  // Piece kinds.
  localparam logic KIND_SURVIVOR = 1'b0;
  localparam logic KIND_REMOVED  = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/acf_box_if.sv
// Input channel of the box cut fracture block: one input box per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface acf_box_if #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic        [INDEX_WIDTH-1:0] source_index;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z,
    output box_max_x, box_max_y, box_max_z, source_index,
    input  ready
  );

  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z,
    input  box_max_x, box_max_y, box_max_z, source_index,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/acf_piece_if.sv
// Output channel of the box cut fracture block: one emitted piece per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface acf_piece_if #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          piece_kind;
  logic signed [COORD_WIDTH-1:0] piece_min_x;
  logic signed [COORD_WIDTH-1:0] piece_min_y;
  logic signed [COORD_WIDTH-1:0] piece_min_z;
  logic signed [COORD_WIDTH-1:0] piece_max_x;
  logic signed [COORD_WIDTH-1:0] piece_max_y;
  logic signed [COORD_WIDTH-1:0] piece_max_z;
  logic        [INDEX_WIDTH-1:0] piece_source;
  logic                          piece_last;

  modport source (
    output valid, piece_kind, piece_min_x, piece_min_y, piece_min_z,
    output piece_max_x, piece_max_y, piece_max_z, piece_source, piece_last,
    input  ready
  );

  modport sink (
    input  valid, piece_kind, piece_min_x, piece_min_y, piece_min_z,
    input  piece_max_x, piece_max_y, piece_max_z, piece_source, piece_last,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/acf_front.sv
// Front end: holds the cut box registers, accepts input boxes and classifies
// them into per-axis spans. Depends on acf_pkg and acf_box_if.
`timescale 1ns / 1ps
`default_nettype none

module acf_front #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16,
  localparam int JobW = 18 * COORD_WIDTH + 7 + INDEX_WIDTH
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [acf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [COORD_WIDTH-1:0]       cfg_data_i,
  acf_box_if.sink                     box_i,
  input  wire                         full_i,
  output logic                        push_o,
  output logic [JobW-1:0]             job_o
);
  import acf_pkg::*;

  // One classified box: all spans of every axis, indexed [axis][span].
  typedef struct packed {
    logic [2:0]                        has_below;
    logic [2:0]                        has_above;
    logic                              overlap;
    logic [INDEX_WIDTH-1:0]            source;
    logic [2:0][2:0][COORD_WIDTH-1:0]  lo;
    logic [2:0][2:0][COORD_WIDTH-1:0]  hi;
  } job_t;

  localparam logic signed [COORD_WIDTH-1:0] One = COORD_WIDTH'(1);

  logic signed [COORD_WIDTH-1:0] cut_lo_q [3];
  logic signed [COORD_WIDTH-1:0] cut_hi_q [3];
  logic signed [COORD_WIDTH-1:0] blo [3];
  logic signed [COORD_WIDTH-1:0] bhi [3];
  logic signed [COORD_WIDTH-1:0] clo_m1;
  logic signed [COORD_WIDTH-1:0] chi_p1;
  logic [2:0]                    ov;
  logic                          overlap;
  job_t                          job;

  // Cut box registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cut_lo_q[a] <= '0;
        cut_hi_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CUT_MIN_X: cut_lo_q[0] <= cfg_data_i;
        CFG_CUT_MIN_Y: cut_lo_q[1] <= cfg_data_i;
        CFG_CUT_MIN_Z: cut_lo_q[2] <= cfg_data_i;
        CFG_CUT_MAX_X: cut_hi_q[0] <= cfg_data_i;
        CFG_CUT_MAX_Y: cut_hi_q[1] <= cfg_data_i;
        CFG_CUT_MAX_Z: cut_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign blo[0] = box_i.box_min_x;
  assign blo[1] = box_i.box_min_y;
  assign blo[2] = box_i.box_min_z;
  assign bhi[0] = box_i.box_max_x;
  assign bhi[1] = box_i.box_max_y;
  assign bhi[2] = box_i.box_max_z;

  // Overlap test over all three axes, then span bounds in one slice per axis.
  always_comb begin
    clo_m1 = '0;
    chi_p1 = '0;
    for (int a = 0; a < 3; a++) begin
      ov[a] = (blo[a] <= cut_hi_q[a]) && (bhi[a] >= cut_lo_q[a]);
    end
    overlap     = &ov;
    job.overlap = overlap;
    job.source  = box_i.source_index;
    for (int a = 0; a < 3; a++) begin
      clo_m1 = cut_lo_q[a] - One;
      chi_p1 = cut_hi_q[a] + One;
      job.has_below[a] = cut_lo_q[a] > blo[a];
      job.has_above[a] = cut_hi_q[a] < bhi[a];
      job.lo[a][SPAN_BELOW] = blo[a];
      job.hi[a][SPAN_BELOW] = (bhi[a] < clo_m1) ? bhi[a] : clo_m1;
      // Without overlap the inside slot carries the box itself.
      if (overlap) begin
        job.lo[a][SPAN_INSIDE] = (blo[a] > cut_lo_q[a]) ? blo[a] : cut_lo_q[a];
        job.hi[a][SPAN_INSIDE] = (bhi[a] < cut_hi_q[a]) ? bhi[a] : cut_hi_q[a];
      end else begin
        job.lo[a][SPAN_INSIDE] = blo[a];
        job.hi[a][SPAN_INSIDE] = bhi[a];
      end
      job.lo[a][SPAN_ABOVE] = (blo[a] > chi_p1) ? blo[a] : chi_p1;
      job.hi[a][SPAN_ABOVE] = bhi[a];
    end
  end

  // A beat is taken whenever the queue has room.
  assign box_i.ready = !full_i;
  assign push_o      = box_i.valid && !full_i;
  assign job_o       = job;

endmodule

`default_nettype wire

FILE: hdl/acf_queue.sv
// Two-entry queue between the classifier and the piece sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module acf_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [WIDTH-1:0]  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  // The count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  // No entry is removed from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0) else $error("queue popped while empty");

  // A lone push grows the count by one.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 2'd1)
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

FILE: hdl/acf_back.sv
// Back end: walks the span combinations of one classified box and emits the
// pieces through an output register. Depends on acf_pkg and acf_piece_if.
`timescale 1ns / 1ps
`default_nettype none

module acf_back #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16,
  localparam int JobW = 18 * COORD_WIDTH + 7 + INDEX_WIDTH
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             q_valid_i,
  input  wire [JobW-1:0]  job_i,
  output logic            pop_o,
  acf_piece_if.source     piece_o
);
  import acf_pkg::*;

  typedef struct packed {
    logic [2:0]                        has_below;
    logic [2:0]                        has_above;
    logic                              overlap;
    logic [INDEX_WIDTH-1:0]            source;
    logic [2:0][2:0][COORD_WIDTH-1:0]  lo;
    logic [2:0][2:0][COORD_WIDTH-1:0]  hi;
  } job_t;

  typedef struct packed {
    span_e ix;
    span_e iy;
    span_e iz;
  } combo_t;

  typedef struct packed {
    logic  wrap;
    span_e idx;
  } adv_t;

  typedef struct packed {
    combo_t c;
    logic   done;
  } step_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SURV,
    PH_LAST
  } phase_e;

  // Next span on one axis; wraps to the first span that exists.
  function automatic adv_t adv_span(span_e idx, logic hb, logic ha);
    adv_t  r;
    span_e first;
    first  = hb ? SPAN_BELOW : SPAN_INSIDE;
    r.wrap = 1'b1;
    r.idx  = first;
    case (idx)
      SPAN_BELOW: begin
        r.wrap = 1'b0;
        r.idx  = SPAN_INSIDE;
      end
      SPAN_INSIDE: begin
        if (ha) begin
          r.wrap = 1'b0;
          r.idx  = SPAN_ABOVE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Next combination with z innermost and x outermost.
  function automatic step_t step_combo(combo_t c, logic [2:0] hb, logic [2:0] ha);
    step_t r;
    adv_t  ax;
    adv_t  ay;
    adv_t  az;
    r.c    = c;
    r.done = 1'b0;
    ax     = adv_span(c.ix, hb[0], ha[0]);
    ay     = adv_span(c.iy, hb[1], ha[1]);
    az     = adv_span(c.iz, hb[2], ha[2]);
    r.c.iz = az.idx;
    if (az.wrap) begin
      r.c.iy = ay.idx;
      if (ay.wrap) begin
        r.c.ix = ax.idx;
        r.done = ax.wrap;
      end
    end
    return r;
  endfunction

  function automatic logic is_center(combo_t c);
    return (c.ix == SPAN_INSIDE) && (c.iy == SPAN_INSIDE) && (c.iz == SPAN_INSIDE);
  endfunction

  // Advance, passing over the all-inside combination.
  function automatic step_t step_skip(combo_t c, logic [2:0] hb, logic [2:0] ha);
    step_t s;
    s = step_combo(c, hb, ha);
    if (!s.done && is_center(s.c)) begin
      s = step_combo(s.c, hb, ha);
    end
    return s;
  endfunction

  phase_e                  state_q;
  job_t                    job_q;
  combo_t                  cur_q;
  logic                    out_valid_q;
  logic                    out_kind_q;
  logic                    out_last_q;
  logic [COORD_WIDTH-1:0]  out_lo_q [3];
  logic [COORD_WIDTH-1:0]  out_hi_q [3];
  logic [INDEX_WIDTH-1:0]  out_src_q;

  job_t                    head;
  combo_t                  first_c;
  step_t                   start_s;
  step_t                   next_s;
  logic                    emit;
  logic                    load;
  logic [1:0]              sel [3];
  logic [COORD_WIDTH-1:0]  pc_lo [3];
  logic [COORD_WIDTH-1:0]  pc_hi [3];

  // Sequencing decisions and the piece that goes out on this beat.
  always_comb begin
    head       = job_t'(job_i);
    first_c.ix = head.has_below[0] ? SPAN_BELOW : SPAN_INSIDE;
    first_c.iy = head.has_below[1] ? SPAN_BELOW : SPAN_INSIDE;
    first_c.iz = head.has_below[2] ? SPAN_BELOW : SPAN_INSIDE;
    if (is_center(first_c)) begin
      start_s = step_combo(first_c, head.has_below, head.has_above);
    end else begin
      start_s.c    = first_c;
      start_s.done = 1'b0;
    end
    next_s = step_skip(cur_q, job_q.has_below, job_q.has_above);

    emit = (state_q != PH_IDLE) && (!out_valid_q || piece_o.ready);
    load = q_valid_i && ((state_q == PH_IDLE) || (emit && (state_q == PH_LAST)));

    if (state_q == PH_LAST) begin
      sel[0] = SPAN_INSIDE;
      sel[1] = SPAN_INSIDE;
      sel[2] = SPAN_INSIDE;
    end else begin
      sel[0] = cur_q.ix;
      sel[1] = cur_q.iy;
      sel[2] = cur_q.iz;
    end
    for (int a = 0; a < 3; a++) begin
      pc_lo[a] = job_q.lo[a][sel[a]];
      pc_hi[a] = job_q.hi[a][sel[a]];
    end
  end

  // Phase, current job and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PH_IDLE;
      job_q       <= '0;
      cur_q       <= '{SPAN_INSIDE, SPAN_INSIDE, SPAN_INSIDE};
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_SURVIVOR;
      out_last_q  <= 1'b0;
      out_src_q   <= '0;
      for (int a = 0; a < 3; a++) begin
        out_lo_q[a] <= '0;
        out_hi_q[a] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_src_q   <= job_q.source;
        for (int a = 0; a < 3; a++) begin
          out_lo_q[a] <= pc_lo[a];
          out_hi_q[a] <= pc_hi[a];
        end
      end else if (piece_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        PH_SURV: begin
          if (emit) begin
            out_kind_q <= KIND_SURVIVOR;
            out_last_q <= 1'b0;
            if (next_s.done) begin
              state_q <= PH_LAST;
            end else begin
              cur_q <= next_s.c;
            end
          end
        end
        PH_LAST: begin
          if (emit) begin
            out_kind_q <= job_q.overlap ? KIND_REMOVED : KIND_SURVIVOR;
            out_last_q <= 1'b1;
            if (!load) begin
              state_q <= PH_IDLE;
            end
          end
        end
        default: ;
      endcase

      // A new box starts on its own or right behind the final piece.
      if (load) begin
        job_q <= head;
        cur_q <= start_s.c;
        if (!head.overlap || start_s.done) begin
          state_q <= PH_LAST;
        end else begin
          state_q <= PH_SURV;
        end
      end
    end
  end

  assign pop_o               = load;
  assign piece_o.valid       = out_valid_q;
  assign piece_o.piece_kind  = out_kind_q;
  assign piece_o.piece_last  = out_last_q;
  assign piece_o.piece_min_x = out_lo_q[0];
  assign piece_o.piece_min_y = out_lo_q[1];
  assign piece_o.piece_min_z = out_lo_q[2];
  assign piece_o.piece_max_x = out_hi_q[0];
  assign piece_o.piece_max_y = out_hi_q[1];
  assign piece_o.piece_max_z = out_hi_q[2];
  assign piece_o.piece_source = out_src_q;

  // The removed box always closes its input box.
  a_removed_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_REMOVED) |-> out_last_q)
    else $error("removed piece not marked last");

  // Final beat with nothing queued leaves the sequencer idle.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (state_q == PH_LAST) && !load |=> state_q == PH_IDLE)
    else $error("sequencer did not go idle after final piece");

  // Jobs are taken only from a non-empty queue.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i) else $error("job taken from empty queue");

endmodule

`default_nettype wire

FILE: hdl/aabb_cut_fracture_core.sv
// A box accepted by the front is written into the job queue, then loaded into
// the sequencer's job register; its pieces, 1 to 27 per box, leave through the
// output register at one piece per cycle while the receiver is ready.
// A two-entry job queue lets the front accept boxes while pieces drain.
// Reset (rst_ni, asynchronous, active low) empties the queue, idles the
// sequencer, drops the output beat and clears all cut registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module aabb_cut_fracture_core #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [acf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [COORD_WIDTH-1:0]       cfg_data_i,
  acf_box_if.sink                     box_i,
  acf_piece_if.source                 piece_o
);
  import acf_pkg::*;

  localparam int JobW = 18 * COORD_WIDTH + 7 + INDEX_WIDTH;

  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  logic [JobW-1:0] job_in;
  logic [JobW-1:0] job_out;

  // Classifier with the cut box registers.
  acf_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .box_i      (box_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Decoupling queue.
  acf_queue #(
    .WIDTH(JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  // Piece sequencer and output register.
  acf_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (job_out),
    .pop_o     (pop),
    .piece_o   (piece_o)
  );

endmodule

`default_nettype wire

FILE: tb/acf_cut_checker.sv
// Checker for the box cut fracture block: watches the box, piece and cut register ports.
// It predicts the pieces of every accepted box and compares them in order.
// Depends on acf_pkg, acf_box_if and acf_piece_if.
`timescale 1ns / 1ps

module acf_cut_checker #(
  parameter int COORD_WIDTH = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [acf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [COORD_WIDTH-1:0]      cfg_data_i,
  acf_box_if                         box_mon,
  acf_piece_if                       piece_mon,
  output int                         fail_count_o,
  output int                         pending_o
);
  import acf_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [INDEX_WIDTH-1:0] index_t;

  typedef struct {
    logic   kind;
    coord_t lo [3];
    coord_t hi [3];
    index_t src;
    logic   last;
  } piece_t;

  piece_t expected_pieces [$];
  int     cut_lo [3];
  int     cut_hi [3];
  string  axis_name [3] = '{"x", "y", "z"};

  function automatic int lesser(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int greater(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Appends one piece at the tail of the expected list.
  function automatic void add_expected(input piece_t p);
    expected_pieces.insert(expected_pieces.size(), p);
  endfunction

  // Splits the accepted box against the cut box and queues the pieces it yields.
  function automatic void predict_pieces();
    int     blo [3];
    int     bhi [3];
    int     lo_v [3][3];
    int     hi_v [3][3];
    span_e  where [3][3];
    int     cnt [3];
    int     pick [3];
    int     core_at [3];
    logic   overlap;
    piece_t p;

    blo[0] = box_mon.box_min_x;
    blo[1] = box_mon.box_min_y;
    blo[2] = box_mon.box_min_z;
    bhi[0] = box_mon.box_max_x;
    bhi[1] = box_mon.box_max_y;
    bhi[2] = box_mon.box_max_z;
    p.src  = box_mon.source_index;
    p.last = 1'b0;

    overlap = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (!(blo[a] <= cut_hi[a] && bhi[a] >= cut_lo[a])) overlap = 1'b0;
    end

    // A box that misses the cut passes through whole.
    if (!overlap) begin
      p.kind = KIND_SURVIVOR;
      for (int a = 0; a < 3; a++) begin
        p.lo[a] = coord_t'(blo[a]);
        p.hi[a] = coord_t'(bhi[a]);
      end
      p.last = 1'b1;
      add_expected(p);
      return;
    end

    // Up to three spans per axis: below the cut, inside it and above it.
    for (int a = 0; a < 3; a++) begin
      cnt[a] = 0;
      if (cut_lo[a] > blo[a]) begin
        lo_v[a][cnt[a]]  = blo[a];
        hi_v[a][cnt[a]]  = lesser(bhi[a], cut_lo[a] - 1);
        where[a][cnt[a]] = SPAN_BELOW;
        cnt[a]++;
      end
      core_at[a]       = cnt[a];
      lo_v[a][cnt[a]]  = greater(blo[a], cut_lo[a]);
      hi_v[a][cnt[a]]  = lesser(bhi[a], cut_hi[a]);
      where[a][cnt[a]] = SPAN_INSIDE;
      cnt[a]++;
      if (cut_hi[a] < bhi[a]) begin
        lo_v[a][cnt[a]]  = greater(blo[a], cut_hi[a] + 1);
        hi_v[a][cnt[a]]  = bhi[a];
        where[a][cnt[a]] = SPAN_ABOVE;
        cnt[a]++;
      end
    end

    // Survivors in x-outer, y, z-inner order, skipping the all-inside combination.
    p.kind = KIND_SURVIVOR;
    for (int i = 0; i < cnt[0]; i++) begin
      for (int j = 0; j < cnt[1]; j++) begin
        for (int k = 0; k < cnt[2]; k++) begin
          pick[0] = i;
          pick[1] = j;
          pick[2] = k;
          if (where[0][i] == SPAN_INSIDE && where[1][j] == SPAN_INSIDE &&
              where[2][k] == SPAN_INSIDE) continue;
          for (int a = 0; a < 3; a++) begin
            p.lo[a] = coord_t'(lo_v[a][pick[a]]);
            p.hi[a] = coord_t'(hi_v[a][pick[a]]);
          end
          add_expected(p);
        end
      end
    end

    // The intersection closes the list for this box.
    p.kind = KIND_REMOVED;
    p.last = 1'b1;
    for (int a = 0; a < 3; a++) begin
      p.lo[a] = coord_t'(lo_v[a][core_at[a]]);
      p.hi[a] = coord_t'(hi_v[a][core_at[a]]);
    end
    add_expected(p);
  endfunction

  task automatic compare_field(input string name, input piece_t want,
                               input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: source %0d field %s expected %0d, got %0d",
               $time, want.src, name, exp_v, got_v);
    end
  endtask

  // Compares one accepted piece beat with the oldest expected piece.
  task automatic check_piece();
    piece_t want;
    coord_t got_lo [3];
    coord_t got_hi [3];

    if (expected_pieces.size() == 0) begin
      fail_count_o++;
      $display("%0t: expected no piece, got a piece with source %0d",
               $time, piece_mon.piece_source);
      return;
    end
    want = expected_pieces.pop_front();
    got_lo[0] = piece_mon.piece_min_x;
    got_lo[1] = piece_mon.piece_min_y;
    got_lo[2] = piece_mon.piece_min_z;
    got_hi[0] = piece_mon.piece_max_x;
    got_hi[1] = piece_mon.piece_max_y;
    got_hi[2] = piece_mon.piece_max_z;
    compare_field("kind", want, want.kind, piece_mon.piece_kind);
    for (int a = 0; a < 3; a++) begin
      compare_field({"min_", axis_name[a]}, want, want.lo[a], got_lo[a]);
      compare_field({"max_", axis_name[a]}, want, want.hi[a], got_hi[a]);
    end
    compare_field("source", want, want.src, piece_mon.piece_source);
    compare_field("last", want, want.last, piece_mon.piece_last);
  endtask

  // Sample every channel at the rising edge; register writes follow the block's reset value.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cut_lo[a] = 0;
        cut_hi[a] = 0;
      end
      expected_pieces.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (piece_mon.valid && piece_mon.ready) check_piece();
      if (box_mon.valid && box_mon.ready) predict_pieces();
      if (cfg_we_i) begin
        if (cfg_idx_i <= CFG_CUT_MIN_Z)
          cut_lo[cfg_idx_i - CFG_CUT_MIN_X] = $signed(cfg_data_i);
        else if (cfg_idx_i <= CFG_CUT_MAX_Z)
          cut_hi[cfg_idx_i - CFG_CUT_MAX_X] = $signed(cfg_data_i);
      end
      pending_o = expected_pieces.size();
    end
  end

endmodule

FILE: tb/tb_aabb_cut_fracture_core.sv
// Top of the box cut fracture testbench: clock, reset, cut register writes and box stimulus.
// Drives aabb_cut_fracture_core and gives the verdict from the count of acf_cut_checker.
// Depends on acf_pkg, acf_box_if, acf_piece_if, the block and the checker.
`timescale 1ns / 1ps

module tb_aabb_cut_fracture_core;
  import acf_pkg::*;

  localparam int CoordW         = 16;
  localparam int IndexW         = 16;
  localparam int ResetCycles    = 4;
  localparam int SettleCycles   = 6;
  localparam int LongHoldCycles = 400;
  localparam int RandomPhases   = 6;
  localparam int BoxesPerPhase  = 42;
  localparam int CoordLow       = -32768;
  localparam int CoordHigh      = 32767;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct {
    coord_t            lo [3];
    coord_t            hi [3];
    logic [IndexW-1:0] src;
  } box_t;

  typedef enum int {
    DRAIN_OPEN,
    DRAIN_RANDOM,
    DRAIN_PERIODIC
  } drain_mode_e;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_reg_e          cfg_idx;
  logic [CoordW-1:0] cfg_data;
  int                fail_count;
  int                pending;
  int                hold_requests;
  int                burst_left;
  bit                sender_gaps;
  int                cut_lo_now [3];
  int                cut_hi_now [3];

  acf_box_if   #(.COORD_WIDTH(CoordW), .INDEX_WIDTH(IndexW)) box ();
  acf_piece_if #(.COORD_WIDTH(CoordW), .INDEX_WIDTH(IndexW)) piece ();

  aabb_cut_fracture_core #(
    .COORD_WIDTH(CoordW),
    .INDEX_WIDTH(IndexW)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .box_i      (box),
    .piece_o    (piece)
  );

  acf_cut_checker #(
    .COORD_WIDTH(CoordW),
    .INDEX_WIDTH(IndexW)
  ) cut_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .box_mon      (box),
    .piece_mon    (piece),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int clamp_coord(int v);
    if (v < CoordLow) return CoordLow;
    if (v > CoordHigh) return CoordHigh;
    return v;
  endfunction

  function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz, int src);
    box_t b;
    b.lo[0] = coord_t'(lx);
    b.lo[1] = coord_t'(ly);
    b.lo[2] = coord_t'(lz);
    b.hi[0] = coord_t'(hx);
    b.hi[1] = coord_t'(hy);
    b.hi[2] = coord_t'(hz);
    b.src   = src[IndexW-1:0];
    return b;
  endfunction

  // A coordinate a little around the cut box on one axis.
  function automatic int near_cut(int a);
    int lo;
    int hi;
    lo = (cut_lo_now[a] < cut_hi_now[a]) ? cut_lo_now[a] : cut_hi_now[a];
    hi = (cut_lo_now[a] < cut_hi_now[a]) ? cut_hi_now[a] : cut_lo_now[a];
    return clamp_coord(lo - 40 + int'($urandom_range(0, hi - lo + 80)));
  endfunction

  // Mostly ordered boxes near the cut; some axes fully random, a few inverted.
  function automatic box_t random_box();
    box_t b;
    int   p;
    int   q;
    int   t;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 7) == 0) begin
        p = coord_t'($urandom());
        q = coord_t'($urandom());
      end else begin
        p = near_cut(a);
        q = near_cut(a);
        if (p > q && $urandom_range(0, 15) != 0) begin
          t = p;
          p = q;
          q = t;
        end
      end
      b.lo[a] = coord_t'(p);
      b.hi[a] = coord_t'(q);
    end
    b.src = IndexW'($urandom());
    return b;
  endfunction

  // Register writes are made at the falling edge, one per cycle.
  task automatic write_cut(input cfg_reg_e idx, input int value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[CoordW-1:0];
    if (idx <= CFG_CUT_MIN_Z) cut_lo_now[idx - CFG_CUT_MIN_X] = value;
    else cut_hi_now[idx - CFG_CUT_MAX_X] = value;
    @(negedge clk);
  endtask

  task automatic set_cut(int lx, int ly, int lz, int hx, int hy, int hz);
    write_cut(CFG_CUT_MIN_X, lx);
    write_cut(CFG_CUT_MIN_Y, ly);
    write_cut(CFG_CUT_MIN_Z, lz);
    write_cut(CFG_CUT_MAX_X, hx);
    write_cut(CFG_CUT_MAX_Y, hy);
    write_cut(CFG_CUT_MAX_Z, hz);
    cfg_we = 1'b0;
  endtask

  // Small cuts around a random center, on some axes fully random bounds.
  task automatic random_cut();
    int center;
    int half;
    int lo [3];
    int hi [3];
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 5) == 0) begin
        lo[a] = coord_t'($urandom());
        hi[a] = coord_t'($urandom());
      end else begin
        center = coord_t'($urandom());
        half   = $urandom_range(0, 30);
        lo[a]  = clamp_coord(center - half);
        hi[a]  = clamp_coord(center + half);
      end
    end
    set_cut(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Offers one box beat; bursts of random length are separated by random gaps while sender_gaps is set.
  task automatic offer_box(input box_t b);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        box.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    box.box_min_x    = b.lo[0];
    box.box_min_y    = b.lo[1];
    box.box_min_z    = b.lo[2];
    box.box_max_x    = b.hi[0];
    box.box_max_y    = b.hi[1];
    box.box_max_z    = b.hi[2];
    box.source_index = b.src;
    box.valid        = 1'b1;
    do @(posedge clk); while (!box.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Stops offering until every expected piece has arrived.
  task automatic wait_drained();
    box.valid  = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Piece receiver: segments of open, random and periodic stalls, plus requested long holds.
  initial begin : piece_drain
    drain_mode_e mode;
    int          seg_left;
    int          holds_done;
    mode        = DRAIN_OPEN;
    seg_left    = 0;
    holds_done  = 0;
    piece.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests > holds_done) begin
        holds_done++;
        piece.ready = 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
      end
      if (seg_left == 0) begin
        mode     = drain_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(16, 96);
      end
      seg_left--;
      case (mode)
        DRAIN_OPEN:     piece.ready = 1'b1;
        DRAIN_RANDOM:   piece.ready = ($urandom_range(0, 2) != 0);
        DRAIN_PERIODIC: piece.ready = (seg_left % 3 != 0);
        default:        piece.ready = 1'b1;
      endcase
    end
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_CUT_MIN_X;
    cfg_data         = '0;
    box.valid        = 1'b0;
    box.box_min_x    = '0;
    box.box_min_y    = '0;
    box.box_min_z    = '0;
    box.box_max_x    = '0;
    box.box_max_y    = '0;
    box.box_max_z    = '0;
    box.source_index = '0;
    hold_requests    = 0;
    burst_left       = 0;
    sender_gaps      = 1'b1;
    for (int a = 0; a < 3; a++) begin
      cut_lo_now[a] = 0;
      cut_hi_now[a] = 0;
    end
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Cut box after reset is the single point at the origin.
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh, 0));
    offer_box(make_box(0, 0, 0, 0, 0, 0, 65535));
    offer_box(make_box(1, -5, -5, 5, 5, 5, 12345));
    wait_drained();

    // Ordinary cut: enclosing, enclosed, touching, missing and inverted boxes.
    set_cut(-100, -50, -20, 100, 50, 20);
    offer_box(make_box(-200, -60, -30, 200, 60, 30, 1));
    offer_box(make_box(-5, -5, -5, 5, 5, 5, 2));
    offer_box(make_box(-300, -50, -20, -100, 50, 20, 3));
    offer_box(make_box(-300, 0, 0, -101, 10, 10, 4));
    offer_box(make_box(0, 51, 0, 10, 90, 10, 5));
    offer_box(make_box(0, 0, -90, 10, 10, -21, 6));
    offer_box(make_box(100, 50, 20, 400, 400, 400, 7));
    offer_box(make_box(-150, -10, -10, 0, 10, 10, 8));
    offer_box(make_box(10, 10, 10, -10, -10, -10, 9));
    offer_box(make_box(50, -60, 0, -50, 60, 0, 10));
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordLow, CoordLow, CoordLow, 65535));
    wait_drained();

    // Cut covering the whole coordinate range removes every box whole.
    set_cut(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh);
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh, 21845));
    offer_box(make_box(1, 2, 3, 4, 5, 6, 43690));
    wait_drained();

    // Inverted cut box: spans overlap and pieces may come out inverted.
    set_cut(CoordHigh, CoordHigh, CoordHigh, CoordLow, CoordLow, CoordLow);
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh, 100));
    offer_box(make_box(0, 0, 0, 0, 0, 0, 101));
    wait_drained();

    // Single-point cuts at the two extreme corners.
    set_cut(CoordHigh, CoordHigh, CoordHigh, CoordHigh, CoordHigh, CoordHigh);
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh, 200));
    wait_drained();
    set_cut(CoordLow, CoordLow, CoordLow, CoordLow, CoordLow, CoordLow);
    offer_box(make_box(CoordLow, CoordLow, CoordLow, CoordHigh, CoordHigh, CoordHigh, 201));
    wait_drained();

    // Random phases, each with a fresh cut box.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      random_cut();
      sender_gaps = (phase != 2);
      if (phase == 1) hold_requests++;
      for (int n = 0; n < BoxesPerPhase; n++) begin
        if (phase == 3 && n == BoxesPerPhase / 2) wait_drained();
        offer_box(random_box());
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
